// ===== rtl/met_pkg.sv =====
// Shared constants, codes and types of the multi-channel echo timer.
package met_pkg;

   // Channel and port geometry.
   localparam int SONARS    = 16;
   localparam int CH_W      = 4;
   localparam int PORT_PINS = 8;
   localparam int PIN_W     = 3;

   // Result queue geometry.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;

   // Request opcodes.
   localparam logic OP_PIN  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Channel phases.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MEAS = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   // Result record kinds.
   localparam logic [1:0] KIND_DIST  = 2'd0;
   localparam logic [1:0] KIND_ITER  = 2'd1;
   localparam logic [1:0] KIND_CYCLE = 2'd2;

   // Configuration register indexes (address bit 2).
   localparam logic REG_ITER_COUNT  = 1'b0;
   localparam logic REG_SONAR_COUNT = 1'b1;

   // Division by 14.5 ticks, done as floor(2*d / 29) with a reciprocal.
   localparam int DIV_DIVISOR = 29;
   localparam int DIV_SHIFT   = 21;
   localparam int DIV_RECIP   = (1 << DIV_SHIFT) / DIV_DIVISOR;

   // Control carried along the result pipeline for one request.
   typedef struct packed {
      logic            is_dist;
      logic [CH_W-1:0] chan;
      logic            restart;
      logic            wrap;
      logic [15:0]     val0;
      logic [15:0]     val1;
   } met_ctl_type;

   // One queue entry: all results of one request (one or two records).
   typedef struct packed {
      logic [1:0]      kind0;
      logic [CH_W-1:0] chan;
      logic [15:0]     value0;
      logic            restart;
      logic            wrap;
      logic [15:0]     value1;
   } met_entry_type;

endpackage

// ===== rtl/met_div.sv =====
// Two-stage divider of a 17-bit value by 29 using a reciprocal multiply.
module met_div
   import met_pkg::*;
(
   input  logic        clock,
   input  logic [16:0] x,
   output logic [15:0] q
);

   logic [33:0] prod_ff;
   logic [33:0] prod_in;
   logic [16:0] x_ff;
   logic [12:0] q_est;
   logic [16:0] rem;
   logic        corr;

   // First stage: multiply by the truncated reciprocal.
   assign prod_in = 34'(x) * 34'(DIV_RECIP);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x;
   end

   // Second stage: the estimate is low by at most one, so fix it with one compare.
   assign q_est = prod_ff[33:DIV_SHIFT];
   assign rem   = x_ff - 17'(q_est) * 17'(DIV_DIVISOR);
   assign corr  = (rem >= 17'(DIV_DIVISOR));
   assign q     = 16'(q_est) + 16'(corr);

endmodule

// ===== rtl/met_rsp_queue.sv =====
// Result queue: holds the results of each request and hands them out one record at a time.
module met_rsp_queue
   import met_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  met_entry_type   push_data,
   output logic [Q_CW-1:0] count,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      rsp_record_kind,
   output logic [CH_W-1:0] rsp_channel,
   output logic [15:0]     rsp_record_value,
   output logic            rsp_restart_timer,
   output logic            rsp_last
);

   met_entry_type   entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;
   logic            second_ff, second_in;
   met_entry_type   head;
   logic            pop;
   logic            take;

   assign head      = entry_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign count     = count_ff;

   // The second record of an entry is always the cycle mark.
   always_comb begin
      if (second_ff) begin
         rsp_record_kind   = KIND_CYCLE;
         rsp_channel       = '0;
         rsp_record_value  = head.value1;
         rsp_restart_timer = 1'b0;
         rsp_last          = 1'b1;
      end else begin
         rsp_record_kind   = head.kind0;
         rsp_channel       = head.chan;
         rsp_record_value  = head.value0;
         rsp_restart_timer = head.restart;
         rsp_last          = !head.wrap;
      end
   end

   // An entry leaves once its last record is taken.
   assign take = rsp_valid && rsp_ready;
   assign pop  = take && rsp_last;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(push) - Q_CW'(pop);
      second_in = second_ff;
      if (pop) begin
         second_in = 1'b0;
      end else if (take) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         second_ff <= second_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/multi_channel_echo_timer_top.sv =====
// Top level of the multi-channel echo timer: request decode, start-time memory and pipeline.
//
//   Port group   Direction   Handshake                  Carries
//   req_*        in          req_valid / req_ready      pin-change or tick request
//   rsp_*        out         rsp_valid / rsp_ready      distance, iteration and cycle marks
//   csr_*        in/out      APB setup + access cycle   iteration_count, sonar_count
//
// A request is taken every cycle while the result queue has room for it. A distance result
// passes through start-time memory read, reciprocal multiply, and correction on its way to
// the queue. A tick gives one or two records, one per cycle at the output while rsp_ready is
// high. Requests that cause no result update state at acceptance. Reset is synchronous; channel
// phases and counters clear at once, the start-time memory needs no clearing. A stalled output
// holds up to four requests' results before req_ready drops.
module multi_channel_echo_timer_top
   import met_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // Request channel.
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_opcode,
   input  logic [15:0]     req_timer_value,
   input  logic [7:0]      req_port_now,
   input  logic [7:0]      req_port_before,
   input  logic            req_port_index,
   input  logic [15:0]     req_fired_mask,
   // Result channel.
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      rsp_record_kind,
   output logic [CH_W-1:0] rsp_channel,
   output logic [15:0]     rsp_record_value,
   output logic            rsp_restart_timer,
   output logic            rsp_last,
   // Configuration port.
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   // Configuration registers.
   logic [7:0]  iter_count_ff, iter_count_in;
   logic [4:0]  sonar_count_ff, sonar_count_in;
   logic        csr_write;

   // Block state.
   logic [1:0]  phase_ff [SONARS];
   logic [1:0]  phase_in [SONARS];
   logic [7:0]  iteration_ff, iteration_in;
   logic [15:0] cycle_ff, cycle_in;
   logic [7:0]  outstanding_ff, outstanding_in;
   logic [15:0] start_mem [SONARS];
   logic [15:0] start_rd_ff;

   // Pipeline control.
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff;
   met_ctl_type s1_ctl_ff, s1_ctl_in;
   met_ctl_type s2_ctl_ff;

   // Request decode.
   logic            accept;
   logic [7:0]      diff;
   logic            any_change;
   logic [PIN_W-1:0] pin;
   logic [CH_W-1:0] ch_sel;
   logic            level;
   logic            rise_ok;
   logic            fall_ok;
   logic [7:0]      out_dec;
   logic [7:0]      iter_inc;
   logic            wrap;
   logic [SONARS-1:0] active;
   logic [4:0]      fired_cnt;

   // Downstream.
   logic [16:0]     div_x;
   logic [15:0]     div_q;
   met_entry_type   push_data;
   logic [Q_CW-1:0] q_count;
   logic [3:0]      in_flight;

   // Configuration write and read.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      iter_count_in  = iter_count_ff;
      sonar_count_in = sonar_count_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_ITER_COUNT:  iter_count_in  = csr_pwdata[7:0];
            REG_SONAR_COUNT: sonar_count_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ITER_COUNT:  csr_prdata = {24'd0, iter_count_ff};
         REG_SONAR_COUNT: csr_prdata = {27'd0, sonar_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Take a request only when the queue can hold everything still in the pipeline.
   assign in_flight = 4'(q_count) + 4'(s1_valid_ff) + 4'(s2_valid_ff);
   assign req_ready = (in_flight < 4'(Q_DEPTH));
   assign accept    = req_valid && req_ready;

   // The lowest changed pin picks the channel.
   assign diff       = req_port_now ^ req_port_before;
   assign any_change = (diff != '0);

   always_comb begin
      pin = '0;
      for (int i = PORT_PINS - 1; i >= 0; i--) begin
         if (diff[i]) begin
            pin = PIN_W'(i);
         end
      end
   end

   assign ch_sel  = {req_port_index, pin};
   assign level   = req_port_now[pin];
   assign rise_ok = accept && (req_opcode == OP_PIN) && any_change && level
                    && (phase_ff[ch_sel] == PH_IDLE);
   assign fall_ok = accept && (req_opcode == OP_PIN) && any_change && !level
                    && (phase_ff[ch_sel] == PH_MEAS);
   assign out_dec = outstanding_ff - 8'd1;

   // Tick bookkeeping: iteration step, wrap and the active channel mask.
   assign iter_inc = iteration_ff + 8'd1;
   assign wrap     = (iter_inc == iter_count_ff);

   always_comb begin
      for (int i = 0; i < SONARS; i++) begin
         active[i] = (5'(i) < sonar_count_ff);
      end
   end

   // Count of fired channels in use, as two short chains.
   always_comb begin
      logic [3:0] lo_cnt;
      logic [3:0] hi_cnt;
      lo_cnt = '0;
      hi_cnt = '0;
      for (int i = 0; i < 8; i++) begin
         lo_cnt = lo_cnt + 4'(req_fired_mask[i] & active[i]);
         hi_cnt = hi_cnt + 4'(req_fired_mask[i+8] & active[i+8]);
      end
      fired_cnt = 5'(lo_cnt) + 5'(hi_cnt);
   end

   // Next state of phases and counters, and the control launched into the pipeline.
   always_comb begin
      for (int i = 0; i < SONARS; i++) begin
         phase_in[i] = phase_ff[i];
      end
      iteration_in   = iteration_ff;
      cycle_in       = cycle_ff;
      outstanding_in = outstanding_ff;
      s1_valid_in    = 1'b0;
      s1_ctl_in      = '0;
      if (accept && (req_opcode == OP_TICK)) begin
         iteration_in     = wrap ? 8'd0 : iter_inc;
         cycle_in         = wrap ? cycle_ff + 16'd1 : cycle_ff;
         outstanding_in   = 8'(fired_cnt);
         for (int i = 0; i < SONARS; i++) begin
            if (active[i]) begin
               phase_in[i] = PH_IDLE;
            end
         end
         s1_valid_in      = 1'b1;
         s1_ctl_in.is_dist = 1'b0;
         s1_ctl_in.wrap   = wrap;
         s1_ctl_in.val0   = 16'(iteration_ff);
         s1_ctl_in.val1   = cycle_ff;
      end else if (rise_ok) begin
         phase_in[ch_sel] = PH_MEAS;
      end else if (fall_ok) begin
         phase_in[ch_sel]  = PH_DONE;
         outstanding_in    = out_dec;
         s1_valid_in       = 1'b1;
         s1_ctl_in.is_dist = 1'b1;
         s1_ctl_in.chan    = ch_sel;
         s1_ctl_in.restart = (out_dec == 8'd0);
         s1_ctl_in.val0    = req_timer_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_count_ff  <= 8'd1;
         sonar_count_ff <= 5'd16;
         for (int i = 0; i < SONARS; i++) begin
            phase_ff[i] <= PH_IDLE;
         end
         iteration_ff   <= '0;
         cycle_ff       <= '0;
         outstanding_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         iter_count_ff  <= iter_count_in;
         sonar_count_ff <= sonar_count_in;
         for (int i = 0; i < SONARS; i++) begin
            phase_ff[i] <= phase_in[i];
         end
         iteration_ff   <= iteration_in;
         cycle_ff       <= cycle_in;
         outstanding_ff <= outstanding_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
      end
   end

   // Start-time memory: written on a rising echo, read on a falling one.
   always_ff @(posedge clock) begin
      if (rise_ok) begin
         start_mem[ch_sel] <= req_timer_value;
      end
      if (fall_ok) begin
         start_rd_ff <= start_mem[ch_sel];
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      s1_ctl_ff <= s1_ctl_in;
      s2_ctl_ff <= s1_ctl_ff;
   end

   // Pulse width doubled, then divided by 29.
   assign div_x = {s1_ctl_ff.val0 - start_rd_ff, 1'b0};

   met_div u_div (
      .clock (clock),
      .x     (div_x),
      .q     (div_q)
   );

   // Assemble the queue entry for this request.
   always_comb begin
      push_data.kind0   = s2_ctl_ff.is_dist ? KIND_DIST : KIND_ITER;
      push_data.chan    = s2_ctl_ff.chan;
      push_data.value0  = s2_ctl_ff.is_dist ? div_q : s2_ctl_ff.val0;
      push_data.restart = s2_ctl_ff.restart;
      push_data.wrap    = s2_ctl_ff.wrap;
      push_data.value1  = s2_ctl_ff.val1;
   end

   met_rsp_queue u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .push              (s2_valid_ff),
      .push_data         (push_data),
      .count             (q_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_channel       (rsp_channel),
      .rsp_record_value  (rsp_record_value),
      .rsp_restart_timer (rsp_restart_timer),
      .rsp_last          (rsp_last)
   );

   // The queue never holds more than its depth, thanks to the request credit.
   assert property (@(posedge clock) disable iff (reset)
      in_flight <= 4'(Q_DEPTH))
      else $error("result queue overcommitted");

   // Restart is only ever flagged on a distance record.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restart_timer |-> rsp_record_kind == KIND_DIST)
      else $error("restart on a mark record");

   // A cycle mark always closes its request's results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == KIND_CYCLE) |-> rsp_last)
      else $error("cycle mark not last");

   // A tick reloads outstanding with the fired count of the channels in use.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_TICK) |=> outstanding_ff == 8'($past(fired_cnt)))
      else $error("outstanding not reloaded on tick");

endmodule

// ===== tb/multi_channel_echo_timer_top_tb.sv =====
// Self-checking testbench of the multi-channel echo timer, with its own prediction of every record.
`timescale 1ns / 100ps

module multi_channel_echo_timer_top_tb;
   import met_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int HALF_ITEMS     = 245;
   localparam int LONG_STALL     = 300;

   // One request as the sender offers it.
   typedef struct {
      logic        opcode;
      logic [15:0] timer;
      logic [7:0]  pins_now;
      logic [7:0]  pins_prev;
      logic        port;
      logic [15:0] fired;
   } echo_req_type;

   // One record as the block should return it.
   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  chan;
      logic [15:0] value;
      logic        restart;
      logic        last;
   } echo_rec_type;

   // Block ports.
   logic            clock;
   logic            reset             = 1'b1;
   logic            req_valid         = 1'b0;
   logic            req_ready;
   logic            req_opcode        = OP_PIN;
   logic [15:0]     req_timer_value   = '0;
   logic [7:0]      req_port_now      = '0;
   logic [7:0]      req_port_before   = '0;
   logic            req_port_index    = 1'b0;
   logic [15:0]     req_fired_mask    = '0;
   logic            rsp_valid;
   logic            rsp_ready         = 1'b0;
   logic [1:0]      rsp_record_kind;
   logic [CH_W-1:0] rsp_channel;
   logic [15:0]     rsp_record_value;
   logic            rsp_restart_timer;
   logic            rsp_last;
   logic            csr_psel          = 1'b0;
   logic            csr_penable       = 1'b0;
   logic            csr_pwrite        = 1'b0;
   logic [2:0]      csr_paddr         = '0;
   logic [31:0]     csr_pwdata        = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   // Stimulus and scoreboard storage.
   echo_req_type pending_reqs[$];
   echo_rec_type expected_records[$];
   echo_req_type next_req;
   echo_req_type seen_req;
   logic      req_taken = 1'b0;
   int        queued_total = 0;
   int        errors = 0;
   int        req_count = 0;
   int        dist_count = 0;
   int        mark_count = 0;

   // Idle rates and the long receiver hold-off request.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_req = 0;
   int stall_seen = 0;
   int stall_left = 0;

   // Predicted block state and register copies.
   logic [7:0]  cfg_iter_count  = 8'd1;
   logic [4:0]  cfg_sonar_count = 5'd16;
   logic [1:0]  ch_phase[16]    = '{default: PH_IDLE};
   logic [15:0] ch_start[16]    = '{default: 16'h0000};
   logic [7:0]  iter_idx        = 8'h00;
   logic [15:0] cycle_ctr       = 16'h0000;
   logic [7:0]  pending_echoes  = 8'h00;

   multi_channel_echo_timer_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_timer_value   (req_timer_value),
      .req_port_now      (req_port_now),
      .req_port_before   (req_port_before),
      .req_port_index    (req_port_index),
      .req_fired_mask    (req_fired_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_channel       (rsp_channel),
      .rsp_record_value  (rsp_record_value),
      .rsp_restart_timer (rsp_restart_timer),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Work out the records of one accepted request and step the predicted state.
   task automatic predict_echo(input echo_req_type r);
      logic [7:0]  diff;
      logic [7:0]  old_iter;
      logic [15:0] width;
      logic [31:0] dist_val;
      int          pin;
      int          ch;
      int          n;
      int          cnt;
      if (r.opcode == OP_PIN) begin
         diff = r.pins_now ^ r.pins_prev;
         if (diff != 8'h00) begin
            // The lowest changed pin picks the channel.
            pin = 0;
            while (!diff[pin]) pin++;
            ch = pin + (r.port ? 8 : 0);
            if (r.pins_now[pin] && ch_phase[ch] == PH_IDLE) begin
               ch_start[ch] = r.timer;
               ch_phase[ch] = PH_MEAS;
            end else if (!r.pins_now[pin] && ch_phase[ch] == PH_MEAS) begin
               // Pulse width over 14.5 ticks per unit, as floor(2 * width / 29).
               width = r.timer - ch_start[ch];
               dist_val = (32'(width) * 32'd2) / 32'd29;
               ch_phase[ch] = PH_DONE;
               pending_echoes = pending_echoes - 8'd1;
               expected_records.push_back('{KIND_DIST, 4'(ch), dist_val[15:0],
                                            pending_echoes == 8'h00, 1'b1});
            end
         end
      end else begin
         // Iteration mark first, then a cycle mark when the iteration wraps.
         old_iter = iter_idx;
         iter_idx = iter_idx + 8'd1;
         if (iter_idx == cfg_iter_count) begin
            iter_idx = 8'h00;
            expected_records.push_back('{KIND_ITER, 4'd0, {8'h00, old_iter}, 1'b0, 1'b0});
            expected_records.push_back('{KIND_CYCLE, 4'd0, cycle_ctr, 1'b0, 1'b1});
            cycle_ctr = cycle_ctr + 16'd1;
         end else begin
            expected_records.push_back('{KIND_ITER, 4'd0, {8'h00, old_iter}, 1'b0, 1'b1});
         end
         // Reload the echo count and rearm the channels in use.
         n = (cfg_sonar_count > 5'd16) ? 16 : int'(cfg_sonar_count);
         cnt = 0;
         for (int i = 0; i < n; i++) cnt += r.fired[i];
         pending_echoes = 8'(cnt);
         for (int i = 0; i < n; i++) ch_phase[i] = PH_IDLE;
      end
   endtask

   // Compare one delivered record with the oldest prediction.
   task automatic check_record();
      echo_rec_type want;
      if (expected_records.size() == 0) begin
         report_mismatch("record with none pending, value", rsp_record_value, 0);
      end else begin
         want = expected_records.pop_front();
         if (rsp_record_kind !== want.kind)
            report_mismatch("record_kind", rsp_record_kind, want.kind);
         if (rsp_channel !== want.chan)
            report_mismatch("channel", rsp_channel, want.chan);
         if (rsp_record_value !== want.value)
            report_mismatch("record_value", rsp_record_value, want.value);
         if (rsp_restart_timer !== want.restart)
            report_mismatch("restart_timer", rsp_restart_timer, want.restart);
         if (rsp_last !== want.last)
            report_mismatch("last", rsp_last, want.last);
      end
      if (rsp_record_kind == KIND_DIST) dist_count++;
      else mark_count++;
   endtask

   // Monitor: sample both handshakes at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) check_record();
         if (req_valid && req_ready) begin
            seen_req.opcode    = req_opcode;
            seen_req.timer     = req_timer_value;
            seen_req.pins_now  = req_port_now;
            seen_req.pins_prev = req_port_before;
            seen_req.port      = req_port_index;
            seen_req.fired     = req_fired_mask;
            predict_echo(seen_req);
            req_count++;
         end
      end
   end

   // Driver: offer the next pending request at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_opcode      <= next_req.opcode;
            req_timer_value <= next_req.timer;
            req_port_now    <= next_req.pins_now;
            req_port_before <= next_req.pins_prev;
            req_port_index  <= next_req.port;
            req_fired_mask  <= next_req.fired;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (stall_req != stall_seen) begin
         stall_seen <= stall_req;
         stall_left <= LONG_STALL;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic echo_req_type raw_item(input logic op, input logic [15:0] t,
                                             input logic [7:0] pins_now,
                                             input logic [7:0] pins_prev,
                                             input logic port, input logic [15:0] fired);
      echo_req_type r;
      r.opcode    = op;
      r.timer     = t;
      r.pins_now  = pins_now;
      r.pins_prev = pins_prev;
      r.port      = port;
      r.fired     = fired;
      return r;
   endfunction

   // Pin change whose lowest changed bit is the given channel's pin.
   function automatic echo_req_type pin_change(input int ch, input bit rising,
                                               input logic [15:0] t);
      logic [7:0] pin_bit;
      logic [7:0] upper;
      logic [7:0] prev_v;
      logic [7:0] now_v;
      pin_bit = 8'(1 << (ch % 8));
      upper   = ~(8'(pin_bit << 1) - 8'd1);
      prev_v  = 8'($urandom);
      now_v   = (prev_v & ~upper) | (8'($urandom) & upper);
      if (rising) begin
         now_v  = now_v | pin_bit;
         prev_v = prev_v & ~pin_bit;
      end else begin
         now_v  = now_v & ~pin_bit;
         prev_v = prev_v | pin_bit;
      end
      return raw_item(OP_PIN, t, now_v, prev_v, ch >= 8, 16'($urandom));
   endfunction

   task automatic offer(input echo_req_type r);
      pending_reqs.push_back(r);
      queued_total++;
   endtask

   // A well-formed burst: a tick, rising edges, then falling edges in shuffled order.
   task automatic queue_echo_burst();
      int          nch;
      int          chs[6];
      logic [15:0] t0[6];
      logic [15:0] mask;
      logic [15:0] fired;
      int          k;
      int          tmp_ch;
      logic [15:0] tmp_t;
      nch  = $urandom_range(1, 6);
      mask = 16'h0000;
      for (int j = 0; j < nch; j++) begin
         chs[j] = $urandom_range(15);
         t0[j]  = 16'($urandom);
         mask[chs[j]] = 1'b1;
      end
      // Half the time the exact set of channels, so the echo count can reach zero.
      case ($urandom_range(3))
         0: fired = 16'($urandom);
         1: fired = 16'hFFFF;
         default: fired = mask;
      endcase
      offer(raw_item(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                     fired));
      for (int j = 0; j < nch; j++) offer(pin_change(chs[j], 1'b1, t0[j]));
      for (int j = nch - 1; j > 0; j--) begin
         k = $urandom_range(j);
         tmp_ch = chs[j]; chs[j] = chs[k]; chs[k] = tmp_ch;
         tmp_t  = t0[j];  t0[j]  = t0[k];  t0[k]  = tmp_t;
      end
      for (int j = 0; j < nch; j++) begin
         if ($urandom_range(9) == 0)
            offer(pin_change(chs[j], 1'b0, 16'($urandom)));
         else
            offer(pin_change(chs[j], 1'b0, t0[j] + 16'($urandom_range(4000))));
      end
   endtask

   // Noise: unchanged pins or fully random requests.
   task automatic queue_noise();
      logic [7:0] pins;
      if ($urandom_range(2) == 0) begin
         pins = 8'($urandom);
         offer(raw_item(OP_PIN, 16'($urandom), pins, pins, 1'($urandom), 16'($urandom)));
      end else begin
         offer(raw_item(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom), 16'($urandom)));
      end
   endtask

   task automatic fill_requests(input int count);
      int target;
      target = queued_total + count;
      while (queued_total < target) begin
         if ($urandom_range(99) < 75) queue_echo_burst();
         else queue_noise();
      end
   endtask

   // Wait until every request is sent and every record has come back, then let it settle.
   task automatic wait_drain();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_ITER_COUNT) cfg_iter_count = val[7:0];
      else cfg_sonar_count = val[4:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Main sequence: reset, directed requests, then three idling phases of random bursts.
   initial begin
      int iter_set[6];
      int sonar_set[6];
      int send_pct[3];
      int recv_pct[3];
      iter_set  = '{3, 255, 0, 1, 7, 2};
      sonar_set = '{16, 0, 20, 8, 12, 16};
      iter_set[4]  = $urandom_range(1, 255);
      sonar_set[4] = $urandom_range(0, 16);
      send_pct = '{31, 63, 0};
      recv_pct = '{63, 31, 0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values.
      offer(raw_item(OP_PIN, 16'h1234, 8'hA5, 8'hA5, 1'b0, 16'h0000));
      offer(raw_item(OP_PIN, 16'hFFFF, 8'h00, 8'h00, 1'b1, 16'hFFFF));
      offer(raw_item(OP_TICK, 16'hFFFF, 8'hFF, 8'h00, 1'b1, 16'hFFFF));
      // Longest pulse on channel 0, then a timer wrap on channel 15.
      offer(raw_item(OP_PIN, 16'h0000, 8'hFF, 8'h00, 1'b0, 16'h0000));
      offer(raw_item(OP_PIN, 16'hFFFF, 8'h00, 8'hFF, 1'b0, 16'hFFFF));
      offer(raw_item(OP_PIN, 16'hFFFF, 8'h80, 8'h00, 1'b1, 16'h0000));
      offer(raw_item(OP_PIN, 16'h0000, 8'h00, 8'h80, 1'b1, 16'hFFFF));
      // Edges that arrive in the wrong phase are ignored.
      offer(pin_change(3, 1'b1, 16'd100));
      offer(pin_change(3, 1'b1, 16'd200));
      offer(pin_change(4, 1'b0, 16'd300));
      offer(pin_change(3, 1'b0, 16'd129));
      offer(pin_change(3, 1'b0, 16'd400));
      offer(pin_change(0, 1'b1, 16'd500));
      // Echo count wraps below zero, then lands exactly on zero.
      offer(raw_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, 16'h0000));
      offer(pin_change(9, 1'b1, 16'd1000));
      offer(pin_change(9, 1'b0, 16'd1500));
      offer(raw_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, 16'h0002));
      offer(pin_change(1, 1'b1, 16'hFFF8));
      offer(pin_change(1, 1'b0, 16'h0006));
      wait_drain();

      // Random phases, two register settings each, draining between halves.
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         for (int h = 0; h < 2; h++) begin
            write_csr(REG_ITER_COUNT, 32'(iter_set[2 * p + h]));
            write_csr(REG_SONAR_COUNT, 32'(sonar_set[2 * p + h]));
            @(posedge clock);
            if (p == 0 && h == 0) stall_req = stall_req + 1;
            fill_requests(HALF_ITEMS);
            wait_drain();
         end
      end

      if (expected_records.size() != 0)
         report_mismatch("records never delivered", 0, expected_records.size());
      $display("Run covered %0d requests and %0d records (%0d distances, %0d marks)",
               req_count, dist_count + mark_count, dist_count, mark_count);
      $display("over seven register settings, three idling mixes and one long output stall.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d records outstanding", expected_records.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/met_pkg.sv
rtl/met_div.sv
rtl/met_rsp_queue.sv
rtl/multi_channel_echo_timer_top.sv
tb/multi_channel_echo_timer_top_tb.sv
